>>> rtl/tlb_fifo_lfu_replacement_core_defines.svh
// ---------------------------------------------------------------------------
// tlb fifo/lfu replacement core: assertion macros
// ---------------------------------------------------------------------------
`ifndef TLB_FIFO_LFU_REPLACEMENT_CORE_DEFINES_SVH
`define TLB_FIFO_LFU_REPLACEMENT_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TLBFL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlbfl assertion failed");

// next-cycle implication, checked out of reset
`define TLBFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlbfl assertion failed");

`endif

>>> rtl/tlbfl_pkg.sv
// ---------------------------------------------------------------------------
// tlbfl_pkg
// shared types and constants of the fully associative tlb core
// ---------------------------------------------------------------------------
package tlbfl_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int PAGE_W  = 20;
  localparam int CNT_W   = 32;

  // request queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LFU  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] frame;
  } req_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } back_state_e;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    return r;
  endfunction

endpackage

>>> rtl/tlb_fifo_lfu_replacement_core.sv
// ---------------------------------------------------------------------------
// tlb_fifo_lfu_replacement_core
// eight-entry fully associative tlb with fifo or lfu replacement
// ---------------------------------------------------------------------------
// channel   direction  handshake                      payload
// request   in         start & !busy                  op_i, page_i, frame_in_i
// result    out        result_valid_o (one cycle)     hit_o, frame_out_o,
//                                                     hits_total_o, misses_total_o
// config    in         cfg_valid_i & cfg_ready_o      cfg_data_i (lfu_mode)
//
// a request enters a two-deep queue; busy rises only when that queue is full.
// the back end takes one request a cycle outside an lfu scan; the result strobes the cycle after.
// an lfu fill that misses with all slots valid walks the use counts, one slot
// a cycle, holding the back end until the walk has passed the last slot.
// reset clears valid bits, use counts, pointer and counters; the receiver
// cannot stall results.
// ---------------------------------------------------------------------------
module tlb_fifo_lfu_replacement_core
  import tlbfl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              op_i,
  input  logic [PAGE_W-1:0] page_i,
  input  logic [PAGE_W-1:0] frame_in_i,
  output logic              result_valid_o,
  output logic              hit_o,
  output logic [PAGE_W-1:0] frame_out_o,
  output logic [CNT_W-1:0]  hits_total_o,
  output logic [CNT_W-1:0]  misses_total_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  logic lfu_mode_q;
  req_t push_req, q_req;
  logic q_full, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfu_mode_q <= MODE_FIFO;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lfu_mode_q <= cfg_data_i;
    end
  end

  assign push_req = '{op: op_i, page: page_i, frame: frame_in_i};
  assign busy     = q_full;

  tlbfl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start),
    .push_req_i  (push_req),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .req_valid_o (q_valid),
    .req_o       (q_req)
  );

  tlbfl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lfu_mode_i   (lfu_mode_q),
    .req_valid_i  (q_valid),
    .req_i        (q_req),
    .pop_o        (q_pop),
    .res_valid_o  (result_valid_o),
    .res_hit_o    (hit_o),
    .res_frame_o  (frame_out_o),
    .res_hits_o   (hits_total_o),
    .res_misses_o (misses_total_o)
  );

endmodule

>>> rtl/tlbfl_front.sv
// ---------------------------------------------------------------------------
// tlbfl_front
// takes requests from the command port into a short queue for the back end
// ---------------------------------------------------------------------------
module tlbfl_front
  import tlbfl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_req_i,
  output logic full_o,
  input  logic pop_i,
  output logic req_valid_o,
  output req_t req_o
);

  req_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o      = (count_q == QCNT_W'(QDEPTH));
  assign req_valid_o = (count_q != '0);
  assign req_o       = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && req_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

>>> rtl/tlbfl_back.sv
// ---------------------------------------------------------------------------
// tlbfl_back
// entry store, parallel tag compare, replacement and statistics counters
// ---------------------------------------------------------------------------
`include "tlb_fifo_lfu_replacement_core_defines.svh"

module tlbfl_back
  import tlbfl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              lfu_mode_i,
  input  logic              req_valid_i,
  input  req_t              req_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output logic              res_hit_o,
  output logic [PAGE_W-1:0] res_frame_o,
  output logic [CNT_W-1:0]  res_hits_o,
  output logic [CNT_W-1:0]  res_misses_o
);

  logic [PAGE_W-1:0] page_q  [ENTRIES];
  logic [PAGE_W-1:0] frame_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]  uses_q  [ENTRIES];
  logic [CNT_W-1:0]  uses_d  [ENTRIES];
  logic [IDX_W-1:0]  wptr_q, wptr_d;
  logic [CNT_W-1:0]  hits_q, hits_d;
  logic [CNT_W-1:0]  misses_q, misses_d;

  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  scan_q, scan_d;
  logic [IDX_W-1:0]  victim_q, victim_d;
  logic [CNT_W-1:0]  min_q, min_d;
  logic [PAGE_W-1:0] pend_page_q, pend_frame_q;

  logic              res_valid_q, res_valid_d;
  logic              res_hit_q;
  logic [PAGE_W-1:0] res_frame_q;

  logic [ENTRIES-1:0] hit_vec;
  logic               hit_any, empty_any;
  logic [IDX_W-1:0]   hit_idx, empty_idx;

  logic               wr_en, clr_uses, take, start_scan;
  logic [IDX_W-1:0]   wr_idx;
  logic [PAGE_W-1:0]  wr_page, wr_frame;
  logic               scan_less;
  logic [IDX_W-1:0]   scan_cand;

  // parallel tag compare, lowest matching slot wins
  always_comb begin
    hit_vec   = '0;
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (page_q[i] == req_i.page);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        empty_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any   = |hit_vec;
  assign empty_any = ~&valid_q;

  assign scan_less = uses_q[scan_q] < min_q;
  assign scan_cand = scan_less ? scan_q : victim_q;

  assign take  = (state_q == S_IDLE) && req_valid_i;
  assign pop_o = take;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_scan) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q == IDX_W'(ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    start_scan = 1'b0;
    wr_en      = 1'b0;
    clr_uses   = 1'b0;
    wr_idx     = wptr_q;
    wr_page    = req_i.page;
    wr_frame   = req_i.frame;
    wptr_d     = wptr_q;
    hits_d     = hits_q;
    misses_d   = misses_q;
    scan_d     = scan_q;
    victim_d   = victim_q;
    min_d      = min_q;
    res_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          res_valid_d = 1'b1;
          if (hit_any) begin
            hits_d = sat_inc(hits_q);
          end else begin
            misses_d = sat_inc(misses_q);
            if (req_i.op == OP_FILL) begin
              if (lfu_mode_i == MODE_FIFO) begin
                wr_en  = 1'b1;
                wr_idx = wptr_q;
                wptr_d = (wptr_q == IDX_W'(ENTRIES - 1)) ? '0 : wptr_q + IDX_W'(1);
              end else if (empty_any) begin
                wr_en    = 1'b1;
                clr_uses = 1'b1;
                wr_idx   = empty_idx;
                wptr_d   = (empty_idx == IDX_W'(ENTRIES - 1)) ? '0
                                                              : empty_idx + IDX_W'(1);
              end else begin
                // all slots full: walk the use counts for the least used
                start_scan = 1'b1;
                scan_d     = IDX_W'(1);
                victim_d   = '0;
                min_d      = uses_q[0];
              end
            end
          end
        end
      end
      S_SCAN: begin
        victim_d = scan_cand;
        if (scan_less) begin
          min_d = uses_q[scan_q];
        end
        scan_d = scan_q + IDX_W'(1);
        if (scan_q == IDX_W'(ENTRIES - 1)) begin
          scan_d   = '0;
          wr_en    = 1'b1;
          clr_uses = 1'b1;
          wr_idx   = scan_cand;
          wr_page  = pend_page_q;
          wr_frame = pend_frame_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < ENTRIES; i++) begin
      uses_d[i] = uses_q[i];
      if (wr_en && (wr_idx == IDX_W'(i))) begin
        valid_d[i] = 1'b1;
        if (clr_uses) begin
          uses_d[i] = '0;
        end
      end else if (take && hit_any && (hit_idx == IDX_W'(i))) begin
        uses_d[i] = sat_inc(uses_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      wptr_q      <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      scan_q      <= '0;
      victim_q    <= '0;
      min_q       <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        uses_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      wptr_q      <= wptr_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      scan_q      <= scan_d;
      victim_q    <= victim_d;
      min_q       <= min_d;
      res_valid_q <= res_valid_d;
      for (int i = 0; i < ENTRIES; i++) begin
        uses_q[i] <= uses_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      page_q[wr_idx]  <= wr_page;
      frame_q[wr_idx] <= wr_frame;
    end
    if (start_scan) begin
      pend_page_q  <= req_i.page;
      pend_frame_q <= req_i.frame;
    end
    if (take) begin
      res_hit_q   <= hit_any;
      res_frame_q <= hit_any ? frame_q[hit_idx] : '0;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_hit_o    = res_hit_q;
  assign res_frame_o  = res_frame_q;
  assign res_hits_o   = hits_q;
  assign res_misses_o = misses_q;

  `TLBFL_ASSERT_IMPL(a_miss_frame_zero, res_valid_q && !res_hit_q, res_frame_q == '0)
  `TLBFL_ASSERT_IMPL(a_scan_only_full, state_q == S_SCAN, &valid_q)
  `TLBFL_ASSERT_NEXT(a_valid_sticky, 1'b1, (valid_q & $past(valid_q)) == $past(valid_q))
  `TLBFL_ASSERT_NEXT(a_one_count_step, take, (hits_q != $past(hits_q)) ||
                     (misses_q != $past(misses_q)) || (&$past(hits_q)) ||
                     (&$past(misses_q)))

endmodule
